@@ hw/rtl/microcode_control_word_decode_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the control-word decoder
// Concurrent checks sampled on the rising clock, muted while reset is high.
// ----------------------------------------------------------------------------
`ifndef MICROCODE_CONTROL_WORD_DECODE_ASSERT_SVH
`define MICROCODE_CONTROL_WORD_DECODE_ASSERT_SVH

// Same-cycle implication
`define MCWD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication
`define MCWD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/mcwd_pkg.sv @@
// ----------------------------------------------------------------------------
// mcwd_pkg
// Control bit positions, opcodes and the per-opcode template table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mcwd_pkg;

   typedef logic [31:0] ctrl_word_type;

   // Control bits
   localparam ctrl_word_type B_IR_IN   = 32'h0000_0001;
   localparam ctrl_word_type B_MEM_ADR = 32'h0000_0002;
   localparam ctrl_word_type B_MEM_IN  = 32'h0000_0004;
   localparam ctrl_word_type B_MEM_OUT = 32'h0000_0008;
   localparam ctrl_word_type B_PC_CNT  = 32'h0000_0010;
   localparam ctrl_word_type B_PC_OUT  = 32'h0000_0020;
   localparam ctrl_word_type B_PC_JMP  = 32'h0000_0040;
   localparam ctrl_word_type B_ALU_A   = 32'h0000_0080;
   localparam ctrl_word_type B_ALU_B   = 32'h0000_0100;
   localparam ctrl_word_type B_ALU_OUT = 32'h0000_0200;
   localparam ctrl_word_type B_ALU_S1  = 32'h0000_0400;
   localparam ctrl_word_type B_ALU_S2  = 32'h0000_0800;
   localparam ctrl_word_type B_ALU_S3  = 32'h0000_1000;
   localparam ctrl_word_type B_SERIAL  = 32'h0000_2000;
   localparam ctrl_word_type B_HALT    = 32'h0000_4000;

   // Register field positions and fixed register numbers
   localparam int SEL_SHIFT = 28;
   localparam int ENA_SHIFT = 24;
   localparam logic [3:0] REG_FLAGS = 4'd12;
   localparam logic [3:0] REG_LINK  = 4'd9;

   localparam ctrl_word_type SEL_FLAGS = ctrl_word_type'(REG_FLAGS) << SEL_SHIFT;
   localparam ctrl_word_type SEL_LINK  = ctrl_word_type'(REG_LINK) << SEL_SHIFT;
   localparam ctrl_word_type ENA_LINK  = ctrl_word_type'(REG_LINK) << ENA_SHIFT;

   // Steps
   localparam logic [2:0] STEP_FETCH0 = 3'd0;
   localparam logic [2:0] STEP_FETCH1 = 3'd1;
   localparam logic [2:0] STEP_FETCH2 = 3'd2;
   localparam logic [2:0] STEP_EXEC0  = 3'd3;
   localparam logic [2:0] STEP_EXEC1  = 3'd4;
   localparam logic [2:0] STEP_EXEC2  = 3'd5;
   localparam logic [2:0] STEP_EXEC3  = 3'd6;

   // Flag bits and jump condition bits of the operand
   localparam int FLAG_ZERO  = 1;
   localparam int FLAG_CARRY = 0;

   // Opcodes
   localparam logic [7:0] OP_LDI   = 8'h00;
   localparam logic [7:0] OP_LD    = 8'h01;
   localparam logic [7:0] OP_ST    = 8'h02;
   localparam logic [7:0] OP_LDX   = 8'h03;
   localparam logic [7:0] OP_JR    = 8'h04;
   localparam logic [7:0] OP_JMP   = 8'h05;
   localparam logic [7:0] OP_HLT   = 8'h06;
   localparam logic [7:0] OP_MOV   = 8'h07;
   localparam logic [7:0] OP_ADD   = 8'h08;
   localparam logic [7:0] OP_SUB   = 8'h09;
   localparam logic [7:0] OP_ALU_A = 8'h0A;
   localparam logic [7:0] OP_ALU_B = 8'h0B;
   localparam logic [7:0] OP_NOT   = 8'h0C;
   localparam logic [7:0] OP_ALU_D = 8'h0D;
   localparam logic [7:0] OP_ALU_E = 8'h0E;
   localparam logic [7:0] OP_ALU_F = 8'h0F;
   localparam logic [7:0] OP_CALL  = 8'h10;
   localparam logic [7:0] OP_RET   = 8'h11;
   localparam logic [7:0] OP_OUT   = 8'h12;
   localparam logic [7:0] OP_CMP   = 8'h13;
   localparam logic [7:0] OP_COUNT = 8'h14;

   // One input word as carried through the input register
   typedef struct packed {
      logic [7:0] opcode;
      logic [7:0] operand_byte;
      logic [2:0] micro_step;
      logic [1:0] cpu_flags;
   } req_word_type;

   // Fixed fetch words for steps 0..2
   function automatic ctrl_word_type fetch_word(input logic [2:0] step);
      ctrl_word_type w;
      w = '0;
      case (step)
         STEP_FETCH0: w = B_MEM_ADR | B_PC_OUT;
         STEP_FETCH1: w = B_MEM_OUT | B_IR_IN;
         STEP_FETCH2: w = B_PC_CNT;
         default:     w = '0;
      endcase
      return w;
   endfunction

   // Template word of an opcode for execute slot idx (step - 3)
   function automatic ctrl_word_type template_word(input logic [7:0] op,
                                                   input logic [2:0] idx);
      ctrl_word_type t [5];
      t = '{default: '0};
      case (op)
         OP_LDI:   t = '{B_MEM_ADR | B_PC_OUT, B_MEM_OUT, B_PC_CNT, '0, '0};
         OP_LD:    t = '{B_MEM_ADR, B_MEM_OUT, '0, '0, '0};
         OP_ST:    t = '{B_MEM_ADR, B_MEM_IN, '0, '0, '0};
         OP_LDX:   t = '{B_MEM_ADR | B_PC_OUT, B_MEM_OUT, B_MEM_ADR, B_MEM_OUT, B_PC_CNT};
         OP_JR:    t = '{B_PC_JMP, '0, '0, '0, '0};
         OP_JMP:   t = '{B_MEM_ADR | B_PC_OUT, B_MEM_OUT | B_PC_JMP, '0, '0, '0};
         OP_HLT:   t = '{B_HALT, '0, '0, '0, '0};
         OP_MOV:   t = '{'0, '0, '0, '0, '0};
         OP_ADD:   t = '{B_ALU_A, B_ALU_B | SEL_FLAGS, B_ALU_OUT, '0, '0};
         OP_SUB:   t = '{B_ALU_A, B_ALU_B | B_ALU_S1 | B_ALU_S2 | B_ALU_S3 | SEL_FLAGS,
                         B_ALU_OUT | B_ALU_S1 | B_ALU_S2 | B_ALU_S3, '0, '0};
         OP_ALU_A: t = '{B_ALU_A, B_ALU_B, B_ALU_OUT | B_ALU_S1 | B_ALU_S3, '0, '0};
         OP_ALU_B: t = '{B_ALU_A, B_ALU_B, B_ALU_OUT | B_ALU_S1 | B_ALU_S2, '0, '0};
         OP_NOT:   t = '{B_ALU_A, B_ALU_OUT | B_ALU_S3, '0, '0, '0};
         OP_ALU_D: t = '{B_ALU_A, B_ALU_B, B_ALU_OUT | B_ALU_S2, '0, '0};
         OP_ALU_E: t = '{B_ALU_A, B_ALU_B, B_ALU_OUT | B_ALU_S2 | B_ALU_S3, '0, '0};
         OP_ALU_F: t = '{B_ALU_A, B_ALU_B, B_ALU_OUT | B_ALU_S1, '0, '0};
         OP_CALL:  t = '{B_PC_OUT | B_MEM_ADR, B_PC_CNT, B_PC_OUT | SEL_LINK,
                         B_MEM_OUT | B_PC_JMP, '0};
         OP_RET:   t = '{B_PC_JMP | ENA_LINK, '0, '0, '0, '0};
         OP_OUT:   t = '{B_SERIAL, '0, '0, '0, '0};
         OP_CMP:   t = '{B_ALU_A, B_ALU_B | B_ALU_S1 | B_ALU_S2 | B_ALU_S3 | SEL_FLAGS,
                         '0, '0, '0};
         default:  t = '{default: '0};
      endcase
      // slots past the fifth never occur for execute steps
      return (idx < 3'd5) ? t[idx] : '0;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/mcwd_stage.sv @@
// ----------------------------------------------------------------------------
// mcwd_stage
// One pipeline register with valid/stall flow control; reloads whenever it
// is empty or its word is being taken downstream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcwd_stage #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_stall,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_stall,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] data_ff;
   logic             load;

   // Free to load when empty or when the held word leaves this cycle
   assign load     = !valid_ff || !out_stall;
   assign in_stall = !load;
   assign valid_in = load ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/mcwd_decode.sv @@
// ----------------------------------------------------------------------------
// mcwd_decode
// Combinational decode of one control-unit address into a control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mcwd_decode
   import mcwd_pkg::*;
(
   input  req_word_type  req,
   output ctrl_word_type control_word
);

   ctrl_word_type w;
   ctrl_word_type xi;
   ctrl_word_type xo;
   ctrl_word_type yo;
   ctrl_word_type alu;
   logic [2:0]    step;
   logic [2:0]    slot;
   logic          skip;

   assign step = req.micro_step;
   assign slot = step - STEP_EXEC0;

   // Register fields: X high nibble, Y low nibble
   assign xi = ctrl_word_type'(req.operand_byte[7:4]) << SEL_SHIFT;
   assign xo = ctrl_word_type'(req.operand_byte[7:4]) << ENA_SHIFT;
   assign yo = ctrl_word_type'(req.operand_byte[3:0]) << ENA_SHIFT;

   // ALU ops: X out, Y out, X in over the first three execute steps
   always_comb begin
      case (step)
         STEP_EXEC0: alu = xo;
         STEP_EXEC1: alu = yo;
         STEP_EXEC2: alu = xi;
         default:    alu = '0;
      endcase
   end

   // Conditional jump whose flag is clear; zero condition checked first
   always_comb begin
      skip = 1'b0;
      if (req.operand_byte[FLAG_ZERO]) begin
         skip = !req.cpu_flags[FLAG_ZERO];
      end else if (req.operand_byte[FLAG_CARRY]) begin
         skip = !req.cpu_flags[FLAG_CARRY];
      end
   end

   always_comb begin
      w = template_word(req.opcode, slot);
      unique case (req.opcode) inside
         OP_LDI: begin
            if (step == STEP_EXEC1) w = w | xi;
         end
         OP_LD: begin
            if (step == STEP_EXEC0) w = w | yo;
            if (step == STEP_EXEC1) w = w | xi;
         end
         OP_ST: begin
            if (step == STEP_EXEC0) w = w | yo;
            if (step == STEP_EXEC1) w = w | xo;
         end
         OP_LDX: begin
            if (step == STEP_EXEC1 || step == STEP_EXEC3) w = w | xi;
            if (step == STEP_EXEC2) w = w | xo;
         end
         OP_JR, OP_OUT: begin
            if (step == STEP_EXEC0) w = w | xo;
         end
         OP_JMP: begin
            if (skip) w = (step == STEP_EXEC0) ? B_PC_CNT : '0;
         end
         OP_MOV: begin
            if (step == STEP_EXEC0) w = w | yo | xi;
         end
         OP_ADD, OP_SUB, OP_ALU_A, OP_ALU_B, OP_ALU_D, OP_ALU_E, OP_ALU_F: begin
            w = w | alu;
         end
         OP_NOT: begin
            if (step == STEP_EXEC0) w = w | xo;
            if (step == STEP_EXEC1) w = w | xi;
         end
         OP_CMP: begin
            if (step == STEP_EXEC0 || step == STEP_EXEC1) w = w | alu;
         end
         default: begin
         end
      endcase

      // Fetch steps first, then undefined opcodes
      if (step < STEP_EXEC0) begin
         control_word = fetch_word(step);
      end else if (req.opcode >= OP_COUNT) begin
         control_word = '0;
      end else begin
         control_word = w;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/microcode_control_word_decode.sv @@
// ----------------------------------------------------------------------------
// microcode_control_word_decode
// Decodes a control-unit address (opcode, operand, step, flags) into a
// 32-bit microcode control word.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one address word per handshake (req_valid high, req_stall
//   low at the clock edge). rsp_* returns the matching control word, one per
//   request, in order.
//   Path: an accepted request passes the input register, the decode logic and
//   the result register before rsp_valid rises.
//   Throughput: one word per cycle; the decode is a single pass of gates
//   between the two registers, so a new request is taken every cycle while
//   the result side keeps up.
//   Stall: when rsp_stall is high the result register holds its word; the
//   input register still takes one more request if empty, and req_stall
//   rises only once both registers are full.
//   Reset: synchronous, active high; both registers are emptied and no
//   result is presented until a new request arrives.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module microcode_control_word_decode
   import mcwd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_opcode,
   input  logic [7:0]  req_operand_byte,
   input  logic [2:0]  req_micro_step,
   input  logic [1:0]  req_cpu_flags,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_control_word
);

   req_word_type  req_word;
   req_word_type  dec_word;
   logic          dec_valid;
   logic          dec_stall;
   ctrl_word_type dec_control_word;

   assign req_word.opcode       = req_opcode;
   assign req_word.operand_byte = req_operand_byte;
   assign req_word.micro_step   = req_micro_step;
   assign req_word.cpu_flags    = req_cpu_flags;

   // Input register
   mcwd_stage #(
      .WIDTH ($bits(req_word_type))
   ) u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_word),
      .out_valid (dec_valid),
      .out_stall (dec_stall),
      .out_data  (dec_word)
   );

   // Decode logic
   mcwd_decode u_decode (
      .req          (dec_word),
      .control_word (dec_control_word)
   );

   // Result register
   mcwd_stage #(
      .WIDTH ($bits(ctrl_word_type))
   ) u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_stall  (dec_stall),
      .in_data   (dec_control_word),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_control_word)
   );

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
`include "microcode_control_word_decode_assert.svh"

   `MCWD_ASSERT_NEXT(a_req_to_dec, clock, reset, req_valid && !req_stall, dec_valid,
      "accepted request did not reach the decode stage")
   `MCWD_ASSERT_NEXT(a_dec_hold, clock, reset, dec_valid && dec_stall,
      dec_valid && $stable(dec_word), "decode stage lost or changed a held word")
   `MCWD_ASSERT_NEXT(a_dec_to_rsp, clock, reset, dec_valid && !dec_stall,
      rsp_valid && (rsp_control_word == $past(dec_control_word)),
      "decoded word not captured in the result register")
   `MCWD_ASSERT_NOW(a_undef_zero, clock, reset,
      dec_valid && (dec_word.opcode >= OP_COUNT) && (dec_word.micro_step >= STEP_EXEC0),
      dec_control_word == '0, "undefined opcode gave a nonzero execute word")

endmodule

`default_nettype wire
